// ===== hdl/fixed_record_event_stream_parser_top_assert.svh =====
// Assertion macros for the fixed-record event stream parser.
`ifndef FIXED_RECORD_EVENT_STREAM_PARSER_TOP_ASSERT_SVH
`define FIXED_RECORD_EVENT_STREAM_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define FRP_ASSERT_NOW(label, clk, rst_n, antecedent, consequent, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(antecedent) |-> (consequent)) else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define FRP_ASSERT_NEXT(label, clk, rst_n, antecedent, consequent, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(antecedent) |=> (consequent)) else $error(msg);
`else
`define FRP_ASSERT_NOW(label, clk, rst_n, antecedent, consequent, msg)
`define FRP_ASSERT_NEXT(label, clk, rst_n, antecedent, consequent, msg)
`endif
`endif

// ===== hdl/frp_pkg.sv =====
// Types, codes and stream layout constants for the fixed-record event stream parser.
`default_nettype none
package frp_pkg;

	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_HEADER,
		PH_RECORD,
		PH_TAIL,
		PH_DONE,
		PH_FAILED
	} phase_t;

	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_MAGIC     = 4'd1;
	localparam logic [3:0] ST_LAYOUT    = 4'd2;
	localparam logic [3:0] ST_TRUNCATED = 4'd3;
	localparam logic [3:0] ST_RESERVED  = 4'd4;
	localparam logic [3:0] ST_TYPE      = 4'd5;
	localparam logic [3:0] ST_SIDE      = 4'd6;
	localparam logic [3:0] ST_PRICE     = 4'd7;
	localparam logic [3:0] ST_QUANTITY  = 4'd8;
	localparam logic [3:0] ST_TRAILING  = 4'd9;

	localparam logic [15:0] HDR_VERSION   = 16'd1;
	localparam logic [15:0] HDR_SIZE      = 16'd16;
	localparam logic [31:0] HDR_REC_SIZE  = 32'd20;

	localparam logic [7:0] KIND_MAX    = 8'd3;
	localparam logic [7:0] KIND_UPDATE = 8'd1;
	localparam logic [7:0] SIDE_MAX    = 8'd1;

	// Byte positions inside header and record
	localparam logic [4:0] POS_MAGIC_LAST = 5'd3;
	localparam logic [4:0] POS_LAYOUT_END = 5'd12;
	localparam logic [4:0] POS_HDR_LAST   = 5'd15;
	localparam logic [4:0] POS_TS_END     = 5'd8;
	localparam logic [4:0] POS_KS_END     = 5'd12;
	localparam logic [4:0] POS_RSV_LAST   = 5'd11;
	localparam logic [4:0] POS_REC_LAST   = 5'd19;

	localparam int TDATA_W = 168;
	localparam int TUSER_W = 5;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] b;
		unique case (idx)
			2'd0: b = 8'h4D;
			2'd1: b = 8'h4B;
			2'd2: b = 8'h54;
			2'd3: b = 8'h31;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/fixed_record_event_stream_parser_top.sv =====
// Top level of the fixed-record event stream parser: byte parser and result register.
//
// Usage:
//   Slave side takes the raw little-endian stream, one byte per transaction.
//   tdata[7:0] is the byte, tuser[0] says the byte is present, tlast marks
//   the end of the stream (after the byte, if any). A 16-byte header
//   (magic, version, header size, record size, record count) is checked,
//   then each 20-byte record is validated and reported.
//   Master side delivers at most one result per input transaction: a
//   record, a clean end (tlast high), or the single error result.
//   A result is registered and valid after the edge that accepts the byte
//   completing it. Throughput: one byte per cycle while the receiver keeps up,
//   set by the one-deep result register, which reloads while it drains.
//   When the receiver stalls and a result is pending, s_axis_tready drops
//   until that result is taken, for every byte; the pending result holds.
//   After the error result or the clean end, further input is accepted and
//   dropped until reset.
//   Reset (arst_n low) returns the parser to the magic search with no
//   result pending and the record counter at zero.
`default_nettype none
module fixed_record_event_stream_parser_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,  // data_byte
	input  wire logic [0:0]                    s_axis_tuser,  // has_byte
	input  wire logic                          s_axis_tlast,  // end_of_input
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// timestamp[63:0], event_kind[65:64], book_side[66], price_value[98:67],
	// quantity_value[130:99], record_number[162:131], zero fill[167:163]
	output logic [frp_pkg::TDATA_W-1:0]        m_axis_tdata,
	// event_valid[0], status_code[4:1]
	output logic [frp_pkg::TUSER_W-1:0]        m_axis_tuser,
	output logic                               m_axis_tlast   // stream_done
);

	`include "fixed_record_event_stream_parser_top_assert.svh"

	// Parser state
	frp_pkg::phase_t phase_q, phase_d;
	logic [4:0]  pos_q, pos_d;
	logic [63:0] layout_q, layout_d;     // version, header size, record size
	logic [31:0] expected_q, expected_d;
	logic [31:0] recs_q, recs_d;
	logic [63:0] ts_q, ts_d;
	logic [31:0] ks_q, ks_d;             // kind, side, reserved
	logic [63:0] pq_q, pq_d;             // price, quantity

	// Result register
	logic                         out_valid_q;
	logic [frp_pkg::TDATA_W-1:0]  out_tdata_q;
	logic [frp_pkg::TUSER_W-1:0]  out_tuser_q;
	logic                         out_last_q;

	logic        accept;
	logic        emit;
	logic        ev;
	logic        done;
	logic [3:0]  status;
	logic [2:0]  lay_idx;
	logic [2:0]  pq_idx;
	logic [7:0]  kd;
	logic [7:0]  sd;
	logic [31:0] pr;
	logic [31:0] qt;
	logic [31:0] recs_inc;
	logic [frp_pkg::TDATA_W-1:0] tdata_d;

	// Take a new byte whenever the result register is free or being drained
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign lay_idx  = pos_q[2:0] - 3'd4;   // header bytes 4..11 -> 0..7
	assign pq_idx   = pos_q[2:0] + 3'd4;   // record bytes 12..19 -> 0..7
	assign recs_inc = recs_q + 32'd1;

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		layout_d   = layout_q;
		expected_d = expected_q;
		recs_d     = recs_q;
		ts_d       = ts_q;
		ks_d       = ks_q;
		pq_d       = pq_q;
		emit       = 1'b0;
		ev         = 1'b0;
		done       = 1'b0;
		status     = frp_pkg::ST_OK;
		kd         = ks_q[7:0];
		sd         = ks_q[15:8];
		pr         = 32'd0;
		qt         = 32'd0;

		if (accept && phase_q != frp_pkg::PH_DONE && phase_q != frp_pkg::PH_FAILED) begin
			if (s_axis_tuser[0]) begin
				unique case (phase_q)
					frp_pkg::PH_MAGIC: begin
						if (s_axis_tdata != frp_pkg::magic_byte(pos_q[1:0])) begin
							status = frp_pkg::ST_MAGIC;
						end else begin
							pos_d = pos_q + 5'd1;
							if (pos_q == frp_pkg::POS_MAGIC_LAST) begin
								phase_d = frp_pkg::PH_HEADER;
							end
						end
					end
					frp_pkg::PH_HEADER: begin
						if (pos_q < frp_pkg::POS_LAYOUT_END) begin
							layout_d[{lay_idx, 3'b000} +: 8] = s_axis_tdata;
						end else begin
							expected_d[{pos_q[1:0], 3'b000} +: 8] = s_axis_tdata;
						end
						pos_d = pos_q + 5'd1;
						if (pos_q == frp_pkg::POS_HDR_LAST) begin
							if (layout_d[15:0] != frp_pkg::HDR_VERSION ||
								layout_d[31:16] != frp_pkg::HDR_SIZE ||
								layout_d[63:32] != frp_pkg::HDR_REC_SIZE) begin
								status = frp_pkg::ST_LAYOUT;
							end else begin
								pos_d   = 5'd0;
								phase_d = (expected_d == 32'd0) ? frp_pkg::PH_TAIL
									: frp_pkg::PH_RECORD;
							end
						end
					end
					frp_pkg::PH_RECORD: begin
						// Each byte lands in its own slot, so no clear is needed per record
						if (pos_q < frp_pkg::POS_TS_END) begin
							ts_d[{pos_q[2:0], 3'b000} +: 8] = s_axis_tdata;
						end else if (pos_q < frp_pkg::POS_KS_END) begin
							ks_d[{pos_q[1:0], 3'b000} +: 8] = s_axis_tdata;
						end else begin
							pq_d[{pq_idx, 3'b000} +: 8] = s_axis_tdata;
						end
						pr = pq_d[31:0];
						qt = pq_d[63:32];
						if (pos_q == frp_pkg::POS_RSV_LAST && ks_d[31:16] != 16'd0) begin
							status = frp_pkg::ST_RESERVED;
						end else if (pos_q == frp_pkg::POS_REC_LAST) begin
							priority if (kd > frp_pkg::KIND_MAX) begin
								status = frp_pkg::ST_TYPE;
							end else if (sd > frp_pkg::SIDE_MAX) begin
								status = frp_pkg::ST_SIDE;
							end else if (pr == 32'd0 || pr[31]) begin
								status = frp_pkg::ST_PRICE;
							end else if (qt == 32'd0 && kd != frp_pkg::KIND_UPDATE) begin
								status = frp_pkg::ST_QUANTITY;
							end else begin
								emit   = 1'b1;
								ev     = 1'b1;
								recs_d = recs_inc;
								pos_d  = 5'd0;
								if (recs_inc == expected_q) begin
									phase_d = frp_pkg::PH_TAIL;
								end
							end
						end else begin
							pos_d = pos_q + 5'd1;
						end
					end
					frp_pkg::PH_TAIL: begin
						status = frp_pkg::ST_TRAILING;
					end
					default: begin
					end
				endcase
			end

			// End of stream is judged on the phase after this byte
			if (status == frp_pkg::ST_OK && s_axis_tlast) begin
				priority if (phase_d == frp_pkg::PH_MAGIC) begin
					status = frp_pkg::ST_MAGIC;
				end else if (phase_d == frp_pkg::PH_TAIL) begin
					done    = 1'b1;
					emit    = 1'b1;
					phase_d = frp_pkg::PH_DONE;
				end else begin
					status = frp_pkg::ST_TRUNCATED;
				end
			end

			// Latch the first error; everything after it is dropped
			if (status != frp_pkg::ST_OK) begin
				emit    = 1'b1;
				phase_d = frp_pkg::PH_FAILED;
			end
		end

		// Record fields read as zero unless a valid record goes out
		tdata_d = '0;
		if (ev) begin
			tdata_d[63:0]   = ts_q;
			tdata_d[65:64]  = kd[1:0];
			tdata_d[66]     = sd[0];
			tdata_d[98:67]  = pr;
			tdata_d[130:99] = qt;
		end
		// Record index when a record goes out, else the count so far: both are recs_q
		tdata_d[162:131] = recs_q;
	end

	// Parser state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= frp_pkg::PH_MAGIC;
			pos_q   <= 5'd0;
			recs_q  <= 32'd0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			recs_q  <= recs_d;
		end
	end

	// Header and record byte stores: every byte is written before it is read
	always_ff @(posedge clk) begin
		layout_q   <= layout_d;
		expected_q <= expected_d;
		ts_q       <= ts_d;
		ks_q       <= ks_d;
		pq_q       <= pq_d;
	end

	// Result register: load on a free or draining slot, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && emit) begin
			out_tdata_q <= tdata_d;
			out_tuser_q <= {status, ev};
			out_last_q  <= done;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_tdata_q;
	assign m_axis_tuser  = out_tuser_q;
	assign m_axis_tlast  = out_last_q;

	// A terminal result (error or clean end) is the last result ever produced
	`FRP_ASSERT_NEXT(a_terminal_is_last, clk, arst_n,
		m_axis_tvalid && m_axis_tready && (m_axis_tuser[4:1] != frp_pkg::ST_OK || m_axis_tlast),
		!m_axis_tvalid, "result produced after a terminal result")

	// A delivered record carries either a clean status or the truncation status
	`FRP_ASSERT_NOW(a_record_status, clk, arst_n,
		m_axis_tvalid && m_axis_tuser[0],
		m_axis_tuser[4:1] == frp_pkg::ST_OK || m_axis_tuser[4:1] == frp_pkg::ST_TRUNCATED,
		"record delivered with an unexpected status")

	// Results without a record keep fields [130:0] at zero, and a clean end carries a clean status
	`FRP_ASSERT_NOW(a_empty_fields_zero, clk, arst_n,
		m_axis_tvalid && !m_axis_tuser[0],
		m_axis_tdata[130:0] == 131'd0 && !(m_axis_tlast && m_axis_tuser[4:1] != frp_pkg::ST_OK),
		"non-record result carries record data")

endmodule
`default_nettype wire
